// ----- rtl/core/tsq_pkg.sv -----
// Package for the time sample qualifier: payload structs, status and report
// codes, register indexes and reset values. No dependencies.
`default_nettype none

package tsq_pkg;

  // Configuration register indexes and reset values
  localparam int unsigned CFG_INDEX_W   = 1;
  localparam int unsigned CFG_DATA_W    = 17;
  localparam int unsigned AGE_W         = 12;
  localparam int unsigned DIFF_W        = 17;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_RECEIVE_AGE      = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_CLOCK_DIFFERENCE = 1'd1;
  localparam logic [AGE_W-1:0]       AGE_RESET  = 12'd5;
  localparam logic [DIFF_W-1:0]      DIFF_RESET = 17'd14400;

  // Nanosecond extension window and scale
  localparam logic [31:0] EXT_WINDOW = 32'd1000;
  localparam logic [9:0]  USEC_SCALE = 10'd1000;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Tick status codes
  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_NO_SOURCE = 3'd1;
  localparam logic [2:0] ST_NOT_READY = 3'd2;
  localparam logic [2:0] ST_BAD_MODE  = 3'd3;
  localparam logic [2:0] ST_CLASH     = 3'd4;
  localparam logic [2:0] ST_STALE     = 3'd5;
  localparam logic [2:0] ST_DIFF      = 3'd6;

  // Poll report codes
  localparam logic [2:0] REP_OK      = 3'd0;
  localparam logic [2:0] REP_FAULT   = 3'd1;
  localparam logic [2:0] REP_CLASH   = 3'd2;
  localparam logic [2:0] REP_BAD     = 3'd3;
  localparam logic [2:0] REP_TIMEOUT = 3'd4;

  // Item modes and segment status codes
  localparam logic       MODE_POLL   = 1'b1;
  localparam logic [1:0] SEG_ABSENT  = 2'd0;
  localparam logic [1:0] SEG_NOT_RDY = 2'd1;

  typedef struct packed {
    logic               mode;
    logic [1:0]         segment_status;
    logic               count_same;
    logic signed [31:0] segment_mode;
    logic signed [63:0] clock_sec;
    logic [19:0]        clock_usec;
    logic [31:0]        clock_nsec;
    logic signed [63:0] recv_sec;
    logic [19:0]        recv_usec;
    logic [31:0]        recv_nsec;
    logic signed [63:0] now_sec;
    logic               samples_pending;
  } tsq_in_t;

  typedef struct packed {
    logic [2:0]         sample_status;
    logic [2:0]         poll_report;
    logic signed [63:0] clock_sec_out;
    logic [29:0]        clock_nsec_out;
    logic signed [63:0] recv_sec_out;
    logic [29:0]        recv_nsec_out;
    logic [15:0]        tally_attempts;
    logic [15:0]        tally_good;
    logic [15:0]        tally_not_ready;
    logic [15:0]        tally_bad;
    logic [15:0]        tally_clash;
  } tsq_out_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic               is_poll;
    logic               pending;
    logic               no_source;
    logic [2:0]         status;
    logic signed [63:0] clock_sec;
    logic [29:0]        clock_nsec;
    logic signed [63:0] recv_sec;
    logic [29:0]        recv_nsec;
  } tsq_job_t;

endpackage

`default_nettype wire

// ----- rtl/core/tsq_front.sv -----
// Front of the time sample qualifier: takes items, holds the limit registers
// and classifies each tick in two stages. Depends on tsq_pkg.
`default_nettype none

module tsq_front
  import tsq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  output logic                        full,
  input  wire tsq_in_t                sample,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                        job_valid,
  output tsq_job_t                    job,
  input  wire logic                   job_full
);

  logic [AGE_W-1:0]  max_receive_age;
  logic [DIFF_W-1:0] max_clock_difference;

  // Stage one: captured item
  logic    s1_valid;
  tsq_in_t s1;

  // Stage two: partial checks
  logic               s2_valid;
  logic               s2_is_poll;
  logic               s2_pending;
  logic               s2_no_source;
  logic [2:0]         s2_pre;
  logic               s2_stale;
  logic               s2_rgt;
  logic [63:0]        s2_mag;
  logic [29:0]        s2_cprod;
  logic [29:0]        s2_rprod;
  logic [31:0]        s2_cgiven;
  logic [31:0]        s2_rgiven;
  logic signed [63:0] s2_csec;
  logic signed [63:0] s2_rsec;

  logic s2_free;
  logic s1_ready;

  logic [2:0]  pre;
  logic        positive;
  logic        mode_invalid;
  logic        age_lt;
  logic [63:0] age_diff;
  logic        stale;
  logic        rgt;
  logic [63:0] mag;
  logic [29:0] cprod;
  logic [29:0] rprod;

  logic [31:0]       cprod32;
  logic [31:0]       rprod32;
  logic              use_given;
  logic [31:0]       cns;
  logic [31:0]       rns;
  logic              borrow;
  logic [DIFF_W:0]   limit;
  logic              diff_fail;
  logic [2:0]        status;

  // Limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_receive_age      <= AGE_RESET;
      max_clock_difference <= DIFF_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_RECEIVE_AGE:      max_receive_age      <= cfg_data[AGE_W-1:0];
        REG_MAX_CLOCK_DIFFERENCE: max_clock_difference <= cfg_data[DIFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow
  assign s2_free   = !s2_valid || !job_full;
  assign s1_ready  = !s1_valid || s2_free;
  assign full      = !s1_ready;
  assign job_valid = s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && s1_ready) begin
      s1 <= sample;
    end
  end

  // Stage one checks: segment status, clash, mode, age, second difference
  always_comb begin
    positive     = (s1.segment_mode != 32'sd0) && !s1.segment_mode[31];
    mode_invalid = s1.segment_mode[31:1] != 31'd0;
    if (s1.segment_status == SEG_ABSENT) begin
      pre = ST_NO_SOURCE;
    end else if (s1.segment_status == SEG_NOT_RDY) begin
      pre = ST_NOT_READY;
    end else if (positive && !s1.count_same) begin
      pre = ST_CLASH;
    end else if (mode_invalid) begin
      pre = ST_BAD_MODE;
    end else begin
      pre = ST_ACCEPTED;
    end
    age_lt   = s1.now_sec < s1.recv_sec;
    age_diff = s1.now_sec - s1.recv_sec;
    stale    = age_lt || (age_diff > {{(64-AGE_W){1'b0}}, max_receive_age});
    rgt      = s1.recv_sec > s1.clock_sec;
    mag      = rgt ? (s1.recv_sec - s1.clock_sec) : (s1.clock_sec - s1.recv_sec);
    cprod    = 30'({10'd0, s1.clock_usec} * USEC_SCALE);
    rprod    = 30'({10'd0, s1.recv_usec} * USEC_SCALE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_free) begin
      s2_is_poll   <= s1.mode == MODE_POLL;
      s2_pending   <= s1.samples_pending;
      s2_no_source <= s1.segment_status == SEG_ABSENT;
      s2_pre       <= pre;
      s2_stale     <= stale;
      s2_rgt       <= rgt;
      s2_mag       <= mag;
      s2_cprod     <= cprod;
      s2_rprod     <= rprod;
      s2_cgiven    <= s1.clock_nsec;
      s2_rgiven    <= s1.recv_nsec;
      s2_csec      <= s1.clock_sec;
      s2_rsec      <= s1.recv_sec;
    end
  end

  // Stage two: nanosecond extension, borrow-corrected difference, verdict
  always_comb begin
    cprod32   = {2'b00, s2_cprod};
    rprod32   = {2'b00, s2_rprod};
    use_given = ((s2_cgiven - cprod32) < EXT_WINDOW) &&
                ((s2_rgiven - rprod32) < EXT_WINDOW);
    cns       = use_given ? s2_cgiven : cprod32;
    rns       = use_given ? s2_rgiven : rprod32;
    borrow    = rns < cns;
    // receive ahead: (d - borrow) > md; otherwise e > md - borrow
    limit     = s2_rgt ? ({1'b0, max_clock_difference} + {{DIFF_W{1'b0}}, borrow})
                       : ({1'b0, max_clock_difference} - {{DIFF_W{1'b0}}, borrow});
    diff_fail = (max_clock_difference != '0) &&
                (s2_mag > {{(64-DIFF_W-1){1'b0}}, limit});
    if (s2_pre != ST_ACCEPTED) begin
      status = s2_pre;
    end else if (s2_stale) begin
      status = ST_STALE;
    end else if (diff_fail) begin
      status = ST_DIFF;
    end else begin
      status = ST_ACCEPTED;
    end
  end

  always_comb begin
    job.is_poll    = s2_is_poll;
    job.pending    = s2_pending;
    job.no_source  = s2_no_source;
    job.status     = status;
    job.clock_sec  = s2_csec;
    job.clock_nsec = cns[29:0];
    job.recv_sec   = s2_rsec;
    job.recv_nsec  = rns[29:0];
  end

endmodule

`default_nettype wire

// ----- rtl/core/tsq_queue.sv -----
// Short show-ahead queue of classified items between front and back.
// Flip-flop storage. Depends on tsq_pkg.
`default_nettype none

module tsq_queue
  import tsq_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     wr_valid,
  input  wire tsq_job_t wr_data,
  output logic          wr_full,
  output logic          rd_valid,
  output tsq_job_t      rd_data,
  input  wire logic     rd_take
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tsq_job_t             slots [DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;
  logic                 do_wr;
  logic                 do_rd;

  assign wr_full  = count == CNT_W'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_valid && !wr_full;
  assign do_rd    = rd_take && rd_valid;

  // Store a beat
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and track fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue fill above depth");

  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> count == $past(count) + 1'b1)
    else $error("queue fill missed a write");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers apart while empty");

endmodule

`default_nettype wire

// ----- rtl/core/tsq_back.sv -----
// Back of the time sample qualifier: applies classified items to the tallies,
// forms poll reports and holds the result register. Depends on tsq_pkg.
`default_nettype none

module tsq_back
  import tsq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     job_valid,
  input  wire tsq_job_t job,
  output logic          job_take,
  output logic          empty,
  input  wire logic     pop,
  output tsq_out_t      result
);

  logic [15:0] attempt_count;
  logic [15:0] good_count;
  logic [15:0] not_ready_count;
  logic [15:0] bad_count;
  logic [15:0] clash_count;
  logic        out_valid;
  tsq_out_t    result_next;
  logic [2:0]  report;
  logic        is_bad;

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    return (c == 16'hFFFF) ? c : c + 16'd1;
  endfunction

  assign job_take = job_valid && (!out_valid || pop);
  assign empty    = !out_valid;

  // Poll report: pending OK, no source fault, else top tally; ties: clash, bad
  always_comb begin
    if (job.pending) begin
      report = REP_OK;
    end else if (job.no_source) begin
      report = REP_FAULT;
    end else if (clash_count >= bad_count && clash_count >= not_ready_count) begin
      report = REP_CLASH;
    end else if (bad_count >= not_ready_count) begin
      report = REP_BAD;
    end else begin
      report = REP_TIMEOUT;
    end
  end

  always_comb begin
    is_bad      = (job.status == ST_BAD_MODE) || (job.status == ST_STALE) ||
                  (job.status == ST_DIFF);
    result_next = '0;
    if (job.is_poll) begin
      result_next.poll_report     = report;
      result_next.tally_attempts  = attempt_count;
      result_next.tally_good      = good_count;
      result_next.tally_not_ready = not_ready_count;
      result_next.tally_bad       = bad_count;
      result_next.tally_clash     = clash_count;
    end else begin
      result_next.sample_status = job.status;
      if (job.status == ST_ACCEPTED) begin
        result_next.clock_sec_out  = job.clock_sec;
        result_next.clock_nsec_out = job.clock_nsec;
        result_next.recv_sec_out   = job.recv_sec;
        result_next.recv_nsec_out  = job.recv_nsec;
      end
    end
  end

  // Update tallies; clear on poll
  always_ff @(posedge clk) begin
    if (rst) begin
      attempt_count   <= '0;
      good_count      <= '0;
      not_ready_count <= '0;
      bad_count       <= '0;
      clash_count     <= '0;
    end else if (job_take) begin
      if (job.is_poll) begin
        attempt_count   <= '0;
        good_count      <= '0;
        not_ready_count <= '0;
        bad_count       <= '0;
        clash_count     <= '0;
      end else begin
        attempt_count <= sat_inc(attempt_count);
        if (job.status == ST_ACCEPTED) begin
          good_count <= sat_inc(good_count);
        end
        if (job.status == ST_NOT_READY) begin
          not_ready_count <= sat_inc(not_ready_count);
        end
        if (job.status == ST_CLASH) begin
          clash_count <= sat_inc(clash_count);
        end
        if (is_bad) begin
          bad_count <= sat_inc(bad_count);
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (job_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      result <= result_next;
    end
  end

  a_good_le_attempts: assert property (@(posedge clk) disable iff (rst)
    good_count <= attempt_count)
    else $error("good tally above attempt tally");

  a_clash_le_attempts: assert property (@(posedge clk) disable iff (rst)
    (clash_count <= attempt_count) && (not_ready_count <= attempt_count))
    else $error("reject tally above attempt tally");

  a_poll_clears: assert property (@(posedge clk) disable iff (rst)
    (job_take && job.is_poll) |=> (attempt_count == '0 && bad_count == '0))
    else $error("tallies not cleared after poll");

  a_take_needs_room: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |-> !job_take)
    else $error("result overwritten before delivery");

endmodule

`default_nettype wire

// ----- rtl/core/time_sample_qualifier_core.sv -----
// Time sample qualifier, top level: front classifier, queue, back tally unit.
// Accepted pushes pass stage one, stage two, the queue and the result register
// before the result shows (empty low). Throughput: one item per cycle while
// pop keeps pace, ticks and polls alike, set by the two-stage front and back.
// Reset (rst, synchronous): tallies cleared, limits to 5 s and 14400 s,
// pipeline, queue and result register empty.
`default_nettype none

module time_sample_qualifier_core
  import tsq_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  output logic                        full,
  input  wire tsq_in_t                sample,
  output logic                        empty,
  input  wire logic                   pop,
  output tsq_out_t                    result,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic     front_valid;
  tsq_job_t front_job;
  logic     queue_full;
  logic     queue_valid;
  tsq_job_t queue_job;
  logic     queue_take;

  tsq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .sample    (sample),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_valid (front_valid),
    .job       (front_job),
    .job_full  (queue_full)
  );

  tsq_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_data  (front_job),
    .wr_full  (queue_full),
    .rd_valid (queue_valid),
    .rd_data  (queue_job),
    .rd_take  (queue_take)
  );

  tsq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (queue_valid),
    .job       (queue_job),
    .job_take  (queue_take),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire
